>>> hw/rtl/http_response_status_body_split_assert.svh
// assertion macros for the http response status and body splitter
`ifndef HTTP_RESPONSE_STATUS_BODY_SPLIT_ASSERT_SVH
`define HTTP_RESPONSE_STATUS_BODY_SPLIT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define HRSBS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define HRSBS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/hrsbs_pkg.sv
// shared widths, character constants and separator progress values for the http response splitter
package hrsbs_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CODE_W = 10;
  localparam int unsigned SEP_W  = 3;

  localparam logic [BYTE_W-1:0] CHAR_H     = 8'h48;
  localparam logic [BYTE_W-1:0] CHAR_T     = 8'h54;
  localparam logic [BYTE_W-1:0] CHAR_P     = 8'h50;
  localparam logic [BYTE_W-1:0] CHAR_SLASH = 8'h2f;
  localparam logic [BYTE_W-1:0] CHAR_DOT   = 8'h2e;
  localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0d;
  localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0a;

  localparam logic [SEP_W-1:0] SEP_NONE = 3'd0;
  localparam logic [SEP_W-1:0] SEP_ONE  = 3'd1;
  localparam logic [SEP_W-1:0] SEP_DONE = 3'd4;

endpackage

>>> hw/rtl/hrsbs_in_if.sv
// input channel: one response byte per transaction
interface hrsbs_in_if;
  logic                          valid;
  logic                          ready;
  logic [hrsbs_pkg::BYTE_W-1:0] response_byte;
  logic                          is_last;

  modport source (output valid, output response_byte, output is_last, input ready);
  modport sink (input valid, input response_byte, input is_last, output ready);
endinterface

>>> hw/rtl/hrsbs_out_if.sv
// output channel: one split result per transaction
interface hrsbs_out_if;
  logic                          valid;
  logic                          ready;
  logic                          body_valid;
  logic [hrsbs_pkg::BYTE_W-1:0] body_byte;
  logic                          status_found;
  logic [hrsbs_pkg::CODE_W-1:0] status_code;
  logic                          header_done;
  logic                          response_end;

  modport source (
    output valid, output body_valid, output body_byte, output status_found,
    output status_code, output header_done, output response_end, input ready
  );
  modport sink (
    input valid, input body_valid, input body_byte, input status_found,
    input status_code, input header_done, input response_end, output ready
  );
endinterface

>>> hw/rtl/http_response_status_body_split.sv
// HTTP response splitter: takes one response byte per transaction and returns one result per
// byte, in the cycle after acceptance, through a single result register. A new byte is taken
// in every cycle that the result register is empty or being drained, so the sustained rate is
// one byte per cycle. A status matcher checks the "HTTP/<digits>.<digits> <three digits>"
// prefix and reports the code; a separator matcher finds the first CR LF CR LF and marks
// every later byte as body. State clears after the byte flagged as last.
`include "http_response_status_body_split_assert.svh"

module http_response_status_body_split (
  input  logic clk,
  input  logic rst,
  hrsbs_in_if.sink    raw,
  hrsbs_out_if.source split
);

  typedef enum logic [3:0] {
    PH_H         = 4'd0,
    PH_T1        = 4'd1,
    PH_T2        = 4'd2,
    PH_P         = 4'd3,
    PH_SLASH     = 4'd4,
    PH_MAJ_FIRST = 4'd5,
    PH_MAJ_MORE  = 4'd6,
    PH_MIN_FIRST = 4'd7,
    PH_MIN_MORE  = 4'd8,
    PH_CODE0     = 4'd9,
    PH_CODE1     = 4'd10,
    PH_CODE2     = 4'd11,
    PH_FOUND     = 4'd12,
    PH_FAIL      = 4'd13
  } phase_t;

  phase_t                        phase;
  phase_t                        phase_next;
  logic [hrsbs_pkg::SEP_W-1:0]  sep;
  logic [hrsbs_pkg::SEP_W-1:0]  sep_next;
  logic [hrsbs_pkg::CODE_W-1:0] acc;
  logic [hrsbs_pkg::CODE_W-1:0] acc_next;
  logic                          accept;
  logic                          is_digit;
  logic [3:0]                    digit_val;
  logic [hrsbs_pkg::BYTE_W-1:0] digit_diff;
  logic [hrsbs_pkg::BYTE_W-1:0] sep_char;
  logic [hrsbs_pkg::BYTE_W-1:0] b;

  assign raw.ready  = !split.valid || split.ready;
  assign accept     = raw.valid && raw.ready;
  assign b          = raw.response_byte;
  assign is_digit   = (b >= hrsbs_pkg::CHAR_ZERO) && (b <= hrsbs_pkg::CHAR_NINE);
  assign digit_diff = b - hrsbs_pkg::CHAR_ZERO;
  assign digit_val  = digit_diff[3:0];

  // status line matcher
  always_comb begin
    phase_next = phase;
    acc_next   = acc;
    case (phase)
      PH_H:         phase_next = (b == hrsbs_pkg::CHAR_H) ? PH_T1 : PH_FAIL;
      PH_T1:        phase_next = (b == hrsbs_pkg::CHAR_T) ? PH_T2 : PH_FAIL;
      PH_T2:        phase_next = (b == hrsbs_pkg::CHAR_T) ? PH_P : PH_FAIL;
      PH_P:         phase_next = (b == hrsbs_pkg::CHAR_P) ? PH_SLASH : PH_FAIL;
      PH_SLASH:     phase_next = (b == hrsbs_pkg::CHAR_SLASH) ? PH_MAJ_FIRST : PH_FAIL;
      PH_MAJ_FIRST: phase_next = is_digit ? PH_MAJ_MORE : PH_FAIL;
      PH_MAJ_MORE: begin
        if (is_digit) phase_next = PH_MAJ_MORE;
        else phase_next = (b == hrsbs_pkg::CHAR_DOT) ? PH_MIN_FIRST : PH_FAIL;
      end
      PH_MIN_FIRST: phase_next = is_digit ? PH_MIN_MORE : PH_FAIL;
      PH_MIN_MORE: begin
        if (is_digit) phase_next = PH_MIN_MORE;
        else phase_next = (b == hrsbs_pkg::CHAR_SPACE) ? PH_CODE0 : PH_FAIL;
      end
      PH_CODE0, PH_CODE1, PH_CODE2: begin
        if (!is_digit) begin
          phase_next = PH_FAIL;
        end else begin
          // acc * 10 + digit, kept to the code width
          acc_next = {acc[6:0], 3'b000} + {acc[8:0], 1'b0} + {6'd0, digit_val};
          case (phase)
            PH_CODE0: phase_next = PH_CODE1;
            PH_CODE1: phase_next = PH_CODE2;
            default:  phase_next = PH_FOUND;
          endcase
        end
      end
      PH_FOUND: phase_next = PH_FOUND;
      default:  phase_next = PH_FAIL;
    endcase
  end

  // separator matcher
  always_comb begin
    case (sep[1:0])
      2'd0:    sep_char = hrsbs_pkg::CHAR_CR;
      2'd1:    sep_char = hrsbs_pkg::CHAR_LF;
      2'd2:    sep_char = hrsbs_pkg::CHAR_CR;
      default: sep_char = hrsbs_pkg::CHAR_LF;
    endcase
    if (sep >= hrsbs_pkg::SEP_DONE) sep_next = hrsbs_pkg::SEP_DONE;
    else if (b == sep_char) sep_next = sep + hrsbs_pkg::SEP_ONE;
    else if (b == hrsbs_pkg::CHAR_CR) sep_next = hrsbs_pkg::SEP_ONE;
    else sep_next = hrsbs_pkg::SEP_NONE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_H;
      sep         <= hrsbs_pkg::SEP_NONE;
      acc         <= '0;
      split.valid <= 1'b0;
    end else begin
      if (accept) begin
        split.valid        <= 1'b1;
        split.body_valid   <= (sep >= hrsbs_pkg::SEP_DONE);
        split.body_byte    <= (sep >= hrsbs_pkg::SEP_DONE) ? b : '0;
        split.status_found <= (phase_next == PH_FOUND);
        split.status_code  <= (phase_next == PH_FOUND) ? acc_next : '0;
        split.header_done  <= (sep_next >= hrsbs_pkg::SEP_DONE);
        split.response_end <= raw.is_last;
        if (raw.is_last) begin
          phase <= PH_H;
          sep   <= hrsbs_pkg::SEP_NONE;
          acc   <= '0;
        end else begin
          phase <= phase_next;
          sep   <= sep_next;
          acc   <= acc_next;
        end
      end else if (split.ready) begin
        split.valid <= 1'b0;
      end
    end
  end

  `HRSBS_ASSERT_NEXT(a_clear_after_last, clk, rst, accept && raw.is_last, phase == PH_H && sep == hrsbs_pkg::SEP_NONE && acc == '0, "state not cleared after last byte")
  `HRSBS_ASSERT_NOW(a_sep_range, clk, rst, 1'b1, sep <= hrsbs_pkg::SEP_DONE, "separator progress out of range")
  `HRSBS_ASSERT_NOW(a_body_after_header, clk, rst, split.valid && split.body_valid, split.header_done, "body byte before header end")
  `HRSBS_ASSERT_NOW(a_found_sticky, clk, rst, split.valid && split.status_found && !split.response_end, phase == PH_FOUND, "status result without matched phase")

endmodule

>>> test/http_response_status_body_split_tb.sv
// testbench for the http response status and body splitter
`timescale 1ns / 100ps

module http_response_status_body_split_tb;

  typedef enum logic [3:0] {
    WANT_H, WANT_T1, WANT_T2, WANT_P, WANT_SLASH,
    MAJOR_FIRST, MAJOR_MORE, MINOR_FIRST, MINOR_MORE,
    CODE_D0, CODE_D1, CODE_D2, STATUS_MATCHED, STATUS_FAILED
  } status_step_t;

  typedef struct packed {
    logic                         body_valid;
    logic [hrsbs_pkg::BYTE_W-1:0] body_byte;
    logic                         status_found;
    logic [hrsbs_pkg::CODE_W-1:0] status_code;
    logic                         header_done;
    logic                         response_end;
  } split_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  hrsbs_in_if  raw_ch ();
  hrsbs_out_if split_ch ();

  http_response_status_body_split DUT (
    .clk   (clk),
    .rst   (rst),
    .raw   (raw_ch),
    .split (split_ch)
  );

  status_step_t                 status_step;
  logic [hrsbs_pkg::SEP_W-1:0]  sep_match;
  logic [hrsbs_pkg::CODE_W-1:0] code_acc;

  split_result_t                expected_splits[$];
  logic [hrsbs_pkg::BYTE_W-1:0] resp_bytes[$];
  int                           byte_count;
  int                           error_count;
  int                           mismatch_count;
  bit                           quiet;
  int                           stall_left;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #400000;
    $display("http_response_status_body_split_tb: errors");
    $finish;
  end

  function automatic bit is_digit(input logic [hrsbs_pkg::BYTE_W-1:0] b);
    return b >= hrsbs_pkg::CHAR_ZERO && b <= hrsbs_pkg::CHAR_NINE;
  endfunction

  function automatic split_result_t predict_split(input logic [hrsbs_pkg::BYTE_W-1:0] b,
                                                  input logic last);
    split_result_t r;
    r.body_valid = sep_match >= hrsbs_pkg::SEP_DONE;
    r.body_byte  = r.body_valid ? b : '0;

    case (status_step)
      WANT_H:      status_step = (b == hrsbs_pkg::CHAR_H) ? WANT_T1 : STATUS_FAILED;
      WANT_T1:     status_step = (b == hrsbs_pkg::CHAR_T) ? WANT_T2 : STATUS_FAILED;
      WANT_T2:     status_step = (b == hrsbs_pkg::CHAR_T) ? WANT_P : STATUS_FAILED;
      WANT_P:      status_step = (b == hrsbs_pkg::CHAR_P) ? WANT_SLASH : STATUS_FAILED;
      WANT_SLASH:  status_step = (b == hrsbs_pkg::CHAR_SLASH) ? MAJOR_FIRST : STATUS_FAILED;
      MAJOR_FIRST: status_step = is_digit(b) ? MAJOR_MORE : STATUS_FAILED;
      MAJOR_MORE:  status_step = is_digit(b) ? MAJOR_MORE :
                                 (b == hrsbs_pkg::CHAR_DOT) ? MINOR_FIRST : STATUS_FAILED;
      MINOR_FIRST: status_step = is_digit(b) ? MINOR_MORE : STATUS_FAILED;
      MINOR_MORE:  status_step = is_digit(b) ? MINOR_MORE :
                                 (b == hrsbs_pkg::CHAR_SPACE) ? CODE_D0 : STATUS_FAILED;
      CODE_D0, CODE_D1, CODE_D2: begin
        if (is_digit(b)) begin
          code_acc = code_acc * 10'd10 + {2'b00, b - hrsbs_pkg::CHAR_ZERO};
          status_step = status_step_t'(status_step + 4'd1);
        end else begin
          status_step = STATUS_FAILED;
        end
      end
      STATUS_MATCHED: status_step = STATUS_MATCHED;
      default:        status_step = STATUS_FAILED;
    endcase

    if (sep_match < hrsbs_pkg::SEP_DONE) begin
      if (b == ((sep_match[0] == 1'b0) ? hrsbs_pkg::CHAR_CR : hrsbs_pkg::CHAR_LF))
        sep_match = sep_match + hrsbs_pkg::SEP_ONE;
      else
        sep_match = (b == hrsbs_pkg::CHAR_CR) ? hrsbs_pkg::SEP_ONE : hrsbs_pkg::SEP_NONE;
    end

    r.status_found = status_step == STATUS_MATCHED;
    r.status_code  = r.status_found ? code_acc : '0;
    r.header_done  = sep_match >= hrsbs_pkg::SEP_DONE;
    r.response_end = last;

    if (last) begin
      status_step = WANT_H;
      sep_match   = hrsbs_pkg::SEP_NONE;
      code_acc    = '0;
    end
    return r;
  endfunction

  task automatic send_byte(input logic [hrsbs_pkg::BYTE_W-1:0] b, input logic last);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      raw_ch.valid         <= 1'b0;
      raw_ch.response_byte <= 8'($urandom);
      raw_ch.is_last       <= 1'($urandom);
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    raw_ch.valid         <= 1'b1;
    raw_ch.response_byte <= b;
    raw_ch.is_last       <= last;
    do @(posedge clk); while (raw_ch.ready !== 1'b1);
    expected_splits.insert(expected_splits.size(), predict_split(b, last));
    byte_count++;
  endtask

  task automatic send_response();
    foreach (resp_bytes[i]) send_byte(resp_bytes[i], i == resp_bytes.size() - 1);
  endtask

  task automatic add_byte(input logic [hrsbs_pkg::BYTE_W-1:0] v);
    resp_bytes.insert(resp_bytes.size(), v);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic push_separator();
    add_byte(hrsbs_pkg::CHAR_CR);
    add_byte(hrsbs_pkg::CHAR_LF);
    add_byte(hrsbs_pkg::CHAR_CR);
    add_byte(hrsbs_pkg::CHAR_LF);
  endtask

  function automatic logic [hrsbs_pkg::BYTE_W-1:0] rand_digit();
    return hrsbs_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [hrsbs_pkg::BYTE_W-1:0] header_char();
    case ($urandom_range(0, 3))
      0:       return hrsbs_pkg::CHAR_CR;
      1:       return hrsbs_pkg::CHAR_LF;
      default: return 8'($urandom_range(8'h20, 8'h7e));
    endcase
  endfunction

  task automatic make_random_response();
    int kind;
    int code_kind;
    int pos;
    resp_bytes.delete();
    kind      = $urandom_range(0, 9);
    code_kind = $urandom_range(0, 7);
    push_text("HTTP/");
    repeat ($urandom_range(1, 3)) add_byte(rand_digit());
    add_byte(hrsbs_pkg::CHAR_DOT);
    repeat ($urandom_range(1, 2)) add_byte(rand_digit());
    add_byte(hrsbs_pkg::CHAR_SPACE);
    repeat (3) begin
      case (code_kind)
        0:       add_byte(hrsbs_pkg::CHAR_ZERO);
        1:       add_byte(hrsbs_pkg::CHAR_NINE);
        default: add_byte(rand_digit());
      endcase
    end
    repeat ($urandom_range(0, 2)) begin
      add_byte(hrsbs_pkg::CHAR_CR);
      add_byte(hrsbs_pkg::CHAR_LF);
      repeat ($urandom_range(1, 6)) add_byte(header_char());
    end
    push_separator();
    repeat ($urandom_range(0, 10)) add_byte(8'($urandom));

    pos = $urandom_range(0, resp_bytes.size() - 1);
    case (kind)
      7: resp_bytes[pos] = 8'($urandom);
      8: while (resp_bytes.size() > pos + 1) void'(resp_bytes.pop_back());
      9: begin
        resp_bytes.delete();
        repeat ($urandom_range(1, 20)) begin
          if ($urandom_range(0, 1)) add_byte(header_char());
          else add_byte(8'($urandom));
        end
      end
      default: ;
    endcase
  endtask

  task automatic test_directed();
    // full status line, partial separator restart, body extremes
    resp_bytes.delete();
    push_text("HTTP/0.9 999");
    add_byte(hrsbs_pkg::CHAR_CR);
    push_separator();
    add_byte(8'hff);
    add_byte(8'h00);
    send_response();
    // one-byte response, prefix fails at once
    send_byte(8'h00, 1'b1);
    // separator cut short by the final byte
    resp_bytes.delete();
    add_byte(hrsbs_pkg::CHAR_CR);
    add_byte(hrsbs_pkg::CHAR_LF);
    add_byte(hrsbs_pkg::CHAR_CR);
    add_byte(8'hff);
    send_response();
  endtask

  task automatic test_random_responses();
    while (byte_count < 490) begin
      make_random_response();
      send_response();
    end
  endtask

  task automatic test_back_to_back();
    int start_count;
    start_count = byte_count;
    quiet = 1'b1;
    while (byte_count < start_count + 60) begin
      make_random_response();
      send_response();
    end
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      split_ch.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 3);
      split_ch.ready <= 1'b0;
    end else begin
      split_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    split_result_t got;
    split_result_t want;
    if (!rst && split_ch.valid === 1'b1 && split_ch.ready === 1'b1) begin
      got.body_valid   = split_ch.body_valid;
      got.body_byte    = split_ch.body_byte;
      got.status_found = split_ch.status_found;
      got.status_code  = split_ch.status_code;
      got.header_done  = split_ch.header_done;
      got.response_end = split_ch.response_end;
      if (expected_splits.size() == 0) begin
        error_count++;
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected transaction: body=%0b/%02h status=%0b/%0d hdr=%0b end=%0b",
                   got.body_valid, got.body_byte, got.status_found, got.status_code,
                   got.header_done, got.response_end);
      end else begin
        want = expected_splits.pop_front();
        if (got.body_valid !== want.body_valid || got.body_byte !== want.body_byte ||
            got.status_found !== want.status_found ||
            got.status_code !== want.status_code ||
            got.header_done !== want.header_done ||
            got.response_end !== want.response_end) begin
          error_count++;
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"mismatch: expected body=%0b/%02h status=%0b/%0d hdr=%0b end=%0b, ",
                      "got body=%0b/%02h status=%0b/%0d hdr=%0b end=%0b"},
                     want.body_valid, want.body_byte, want.status_found, want.status_code,
                     want.header_done, want.response_end,
                     got.body_valid, got.body_byte, got.status_found, got.status_code,
                     got.header_done, got.response_end);
        end
      end
    end
  end

  initial begin
    raw_ch.valid         = 1'b0;
    raw_ch.response_byte = '0;
    raw_ch.is_last       = 1'b0;
    split_ch.ready       = 1'b1;
    status_step          = WANT_H;
    sep_match            = hrsbs_pkg::SEP_NONE;
    code_acc             = '0;
    byte_count           = 0;
    error_count          = 0;
    mismatch_count       = 0;
    quiet                = 1'b0;
    stall_left           = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_random_responses();
    test_back_to_back();

    @(negedge clk);
    raw_ch.valid <= 1'b0;
    while (expected_splits.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (expected_splits.size() != 0) error_count++;

    if (error_count == 0) begin
      $display("http_response_status_body_split_tb: clean");
    end else begin
      $display("http_response_status_body_split_tb: errors");
    end
    $finish;
  end

endmodule

>>> http_response_status_body_split.f
+incdir+hw/rtl
hw/rtl/hrsbs_pkg.sv
hw/rtl/hrsbs_in_if.sv
hw/rtl/hrsbs_out_if.sv
hw/rtl/http_response_status_body_split.sv
test/http_response_status_body_split_tb.sv
